### rtl/dlpd_pkg.sv
// Shared types, codes and pixel-mode decode for the display list pixel decoder.
package dlpd_pkg;

   // input command codes (carried on tuser)
   localparam logic [1:0] CMD_COLOR  = 2'd0;
   localparam logic [1:0] CMD_HEADER = 2'd1;
   localparam logic [1:0] CMD_GFX    = 2'd2;

   // queue entry kinds
   localparam logic JOB_COLOR = 1'b0;
   localparam logic JOB_DRAW  = 1'b1;

   // pixel modes: {object write mode, read mode}
   localparam logic [2:0] MODE_160A     = 3'd0;
   localparam logic [2:0] MODE_160A_ALT = 3'd1;
   localparam logic [2:0] MODE_320D     = 3'd2;
   localparam logic [2:0] MODE_320A     = 3'd3;
   localparam logic [2:0] MODE_160B     = 3'd4;
   localparam logic [2:0] MODE_160B_ALT = 3'd5;
   localparam logic [2:0] MODE_320B     = 3'd6;
   localparam logic [2:0] MODE_320C     = 3'd7;

   // holey zone checks
   localparam logic [15:0] HOLE_16K = 16'h9000;
   localparam logic [15:0] HOLE_8K  = 16'h8800;

   // write-enable masks of the two-pair modes
   localparam logic [7:0] MASK_320B_FIRST  = 8'hCC;
   localparam logic [7:0] MASK_320B_SECOND = 8'h33;
   localparam logic [7:0] MASK_320C_FIRST  = 8'hC0;
   localparam logic [7:0] MASK_320C_SECOND = 8'h30;

   localparam int PAL_ENTRIES = 24;

   // CSR register indexes (paddr[2])
   localparam logic CSR_READ_MODE = 1'b0;
   localparam logic CSR_KANGAROO  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [2:0] mode;
      logic [2:0] pal;
      logic [7:0] value;
      logic [4:0] reg_index;
      logic [8:0] pos;
   } job_type;

   typedef struct packed {
      logic       push;
      job_type    job;
   } push_type;

   // palette/color index pair for left and right pixel
   typedef struct packed {
      logic [2:0] lp;
      logic [1:0] lk;
      logic [2:0] rp;
      logic [1:0] rk;
      logic       we;
   } pair_type;

   // palette p color k (k != 0) lives at 3p + k - 1
   function automatic logic [4:0] color_addr(input logic [2:0] p, input logic [1:0] k);
      color_addr = {1'b0, p, 1'b0} + {2'b00, p} + {3'b000, k} - 5'd1;
   endfunction

   function automatic pair_type decode_pair(input logic [2:0] mode, input logic [2:0] pal,
                                            input logic [7:0] d, input logic [1:0] idx,
                                            input logic kang);
      pair_type   p;
      logic [2:0] hb;
      logic [2:0] lb;
      logic       hi;
      logic       lo;
      logic [1:0] c;
      logic [2:0] q;
      hb = 3'd7 - {idx, 1'b0};
      lb = 3'd6 - {idx, 1'b0};
      hi = d[hb];
      lo = d[lb];
      c  = {hi, lo};
      p  = '0;
      case (mode)
         MODE_160A, MODE_160A_ALT: begin
            p.lp = pal;  p.lk = c;
            p.rp = pal;  p.rk = c;
            p.we = (c != 2'd0) || kang;
         end
         MODE_320D: begin
            q    = {pal[2], 2'b00};
            p.lp = q;    p.lk = {hi, pal[1]};
            p.rp = q;    p.rk = {lo, pal[0]};
            p.we = hi || lo || (pal[1:0] != 2'd0) || kang;
         end
         MODE_320A: begin
            p.lp = pal;  p.lk = {hi, 1'b0};
            p.rp = pal;  p.rk = {lo, 1'b0};
            p.we = hi || lo || kang;
         end
         MODE_160B, MODE_160B_ALT: begin
            if (!idx[0]) begin
               c = d[7:6];
               q = {pal[2], d[3:2]};
            end else begin
               c = d[5:4];
               q = {pal[2], d[1:0]};
            end
            p.lp = q;    p.lk = c;
            p.rp = q;    p.rk = c;
            p.we = (c != 2'd0) || kang;
         end
         MODE_320B: begin
            p.lp = pal;
            p.rp = pal;
            if (!idx[0]) begin
               p.lk = {d[7], d[3]};
               p.rk = {d[6], d[2]};
               p.we = ((d & MASK_320B_FIRST) != 8'd0) || kang;
            end else begin
               p.lk = {d[5], d[1]};
               p.rk = {d[4], d[0]};
               p.we = ((d & MASK_320B_SECOND) != 8'd0) || kang;
            end
         end
         MODE_320C: begin
            if (!idx[0]) begin
               q    = {pal[2], d[3:2]};
               p.lk = {d[7], 1'b0};
               p.rk = {d[6], 1'b0};
               p.we = ((d & MASK_320C_FIRST) != 8'd0) || kang;
            end else begin
               q    = {pal[2], d[1:0]};
               p.lk = {d[5], 1'b0};
               p.rk = {d[4], 1'b0};
               p.we = ((d & MASK_320C_SECOND) != 8'd0) || kang;
            end
            p.lp = q;
            p.rp = q;
         end
         default: begin
            p = '0;
         end
      endcase
      decode_pair = p;
   endfunction

endpackage

### rtl/dlpd_front.sv
// Front end: accepts input beats, tracks object header state, queues color writes and draws.
module dlpd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,
   input  logic [1:0]         req_tuser,
   input  logic [1:0]         read_mode,
   input  logic               queue_full,
   output dlpd_pkg::push_type push_out
);
   import dlpd_pkg::*;

   logic [4:0]  reg_index;
   logic [7:0]  value;
   logic [2:0]  palette_group;
   logic        write_mode;
   logic [15:0] fetch_addr;
   logic [1:0]  holey;

   logic [8:0]  pos_ff, pos_in;
   logic [2:0]  pal_ff, pal_in;
   logic        wm_ff, wm_in;

   logic        accept;
   logic        hole;
   logic        color_ok;
   logic [2:0]  mode;

   assign reg_index     = req_tdata[4:0];
   assign value         = req_tdata[12:5];
   assign palette_group = req_tdata[15:13];
   assign write_mode    = req_tdata[16];
   assign fetch_addr    = req_tdata[32:17];
   assign holey         = req_tdata[34:33];

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign mode       = {wm_ff, read_mode};

   assign hole = (holey[1] && ((fetch_addr & HOLE_16K) == HOLE_16K)) ||
                 (holey[0] && ((fetch_addr & HOLE_8K) == HOLE_8K));
   // index 0 is the background; other multiples of four are not color registers
   assign color_ok = (reg_index == 5'd0) || (reg_index[1:0] != 2'd0);

   always_comb begin
      pos_in = pos_ff;
      pal_in = pal_ff;
      wm_in  = wm_ff;
      push_out.push          = 1'b0;
      push_out.job.kind      = JOB_COLOR;
      push_out.job.mode      = mode;
      push_out.job.pal       = pal_ff;
      push_out.job.value     = value;
      push_out.job.reg_index = reg_index;
      push_out.job.pos       = pos_ff;
      if (accept) begin
         case (req_tuser)
            CMD_COLOR: begin
               push_out.push = color_ok;
            end
            CMD_HEADER: begin
               pos_in = {value, 1'b0};
               pal_in = palette_group;
               wm_in  = write_mode;
            end
            CMD_GFX: begin
               if (!hole) begin
                  push_out.push     = 1'b1;
                  push_out.job.kind = JOB_DRAW;
                  pos_in = pos_ff + (mode[2] ? 9'd4 : 9'd8);
               end
            end
            default: begin
               push_out.push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         pal_ff <= '0;
         wm_ff  <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         pal_ff <= pal_in;
         wm_ff  <= wm_in;
      end
   end

   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == CMD_HEADER) |=> (pos_ff == {$past(value), 1'b0}))
      else $error("header position not latched");

endmodule

### rtl/dlpd_queue.sv
// Short FIFO of jobs between the front end and the pixel back end.
module dlpd_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  dlpd_pkg::push_type push_in,
   output logic               full,
   output logic               head_valid,
   output dlpd_pkg::job_type  head,
   input  logic               pop
);
   import dlpd_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push_in.push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push_in.push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push)
         slot_ff[wr_ptr_ff] <= push_in.job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

### rtl/dlpd_back.sv
// Back end: color register file and pair sequencer driving the result register.
module dlpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              kangaroo_mode,
   input  logic              head_valid,
   input  dlpd_pkg::job_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);
   import dlpd_pkg::*;

   logic [7:0]              pal_mem [PAL_ENTRIES];
   logic [PAL_ENTRIES-1:0]  pal_vld_ff, pal_vld_in;
   logic [7:0]              bg_ff, bg_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    out_vld_ff, out_vld_in;
   logic [8:0]              x_ff;
   logic [7:0]              left_ff;
   logic [7:0]              right_ff;
   logic                    we_ff;
   logic                    last_ff;

   logic                    adv;
   logic                    do_write;
   logic                    do_draw;
   logic                    last_pair;
   pair_type                pair;
   logic [4:0]              wa;
   logic [4:0]              la;
   logic [4:0]              ra;

   assign adv       = !out_vld_ff || rsp_tready;
   assign do_write  = head_valid && (head.kind == JOB_COLOR);
   assign do_draw   = head_valid && (head.kind == JOB_DRAW) && adv;
   assign last_pair = head.mode[2] ? (cnt_ff == 2'd1) : (cnt_ff == 2'd3);
   assign pop       = do_write || (do_draw && last_pair);

   assign pair = decode_pair(head.mode, head.pal, head.value, cnt_ff, kangaroo_mode);
   assign wa   = color_addr(head.reg_index[4:2], head.reg_index[1:0]);
   assign la   = color_addr(pair.lp, pair.lk);
   assign ra   = color_addr(pair.rp, pair.rk);

   always_comb begin
      bg_in      = bg_ff;
      pal_vld_in = pal_vld_ff;
      if (do_write) begin
         if (head.reg_index == 5'd0)
            bg_in = head.value;
         else
            pal_vld_in[wa] = 1'b1;
      end
      cnt_in = cnt_ff;
      if (do_draw)
         cnt_in = last_pair ? 2'd0 : cnt_ff + 2'd1;
      if (do_draw)
         out_vld_in = 1'b1;
      else if (rsp_tready)
         out_vld_in = 1'b0;
      else
         out_vld_in = out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
         bg_ff      <= '0;
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         pal_vld_ff <= pal_vld_in;
         bg_ff      <= bg_in;
         cnt_ff     <= cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // color register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (do_write && head.reg_index != 5'd0)
         pal_mem[wa] <= head.value;
      if (do_draw) begin
         x_ff     <= head.pos + {6'd0, cnt_ff, 1'b0};
         left_ff  <= (pair.lk == 2'd0) ? bg_ff : (pal_vld_ff[la] ? pal_mem[la] : 8'd0);
         right_ff <= (pair.rk == 2'd0) ? bg_ff : (pal_vld_ff[ra] ? pal_mem[ra] : 8'd0);
         we_ff    <= pair.we;
         last_ff  <= last_pair;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, right_ff, left_ff, x_ff};
   assign rsp_tuser  = we_ff;
   assign rsp_tlast  = last_ff;

   a_mid_byte_draw: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (head_valid && head.kind == JOB_DRAW))
      else $error("pair counter running without a draw at the head");

   a_pair_step: assert property (@(posedge clock) disable iff (reset)
      (do_draw && !last_pair) |=> (cnt_ff != 2'd0))
      else $error("pair counter lost a step");

endmodule

### rtl/display_list_pixel_decoder.sv
// Top level of the display list pixel decoder: CSR block, front end, job queue and back end.
//
//  channel  dir  handshake               payload
//  req_     in   req_tvalid/req_tready   tdata: reg_index, value, palette_group, write_mode,
//                                        fetch_addr, holey; tuser: cmd
//  rsp_     out  rsp_tvalid/rsp_tready   tdata: pixel_x, left_color, right_color;
//                                        tuser: write_enable; tlast: last
//  csr_     in   APB psel/penable        reg 0 read_mode (0x0), reg 1 kangaroo_mode (0x4)
//
//  A graphics byte gives one beat per cycle unless stalled: 4 beats in 160A/320D/320A, 2 in
//  160B/320B/320C, set by the single pair sequencer in the back end. Headers, dropped bytes
//  and unused commands stay in the front end; color writes go to the back end and give no
//  beat. A byte's first beat passes the queue write, then the result register. Input beats
//  are taken while the job queue has room, so the front end runs ahead of a stalled output
//  by QUEUE_DEPTH items. Reset clears all valid state; no clearing pass is needed.
module display_list_pixel_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // reg_index[4:0] value[12:5] palette_group[15:13]
                                    // write_mode[16] fetch_addr[32:17] holey[34:33]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_x[8:0] left_color[16:9] right_color[24:17]
   output logic        rsp_tuser,   // write_enable[0]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dlpd_pkg::*;

   logic [1:0] read_mode_ff, read_mode_in;
   logic       kang_ff, kang_in;
   logic       csr_wr;

   push_type   push;
   logic       queue_full;
   logic       head_valid;
   job_type    head;
   logic       pop;

   // CSR: zero-wait-state APB, register picked by paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      read_mode_in = read_mode_ff;
      kang_in      = kang_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_READ_MODE: read_mode_in = csr_pwdata[1:0];
            CSR_KANGAROO:  kang_in      = csr_pwdata[0];
            default:       read_mode_in = read_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_READ_MODE: csr_prdata = {30'd0, read_mode_ff};
         CSR_KANGAROO:  csr_prdata = {31'd0, kang_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_mode_ff <= '0;
         kang_ff      <= 1'b0;
      end else begin
         read_mode_ff <= read_mode_in;
         kang_ff      <= kang_in;
      end
   end

   // front: header state, position tracking, hole filter
   dlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .read_mode  (read_mode_ff),
      .queue_full (queue_full),
      .push_out   (push)
   );

   // jobs in order: color writes and draws share one queue so writes land between bytes
   dlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // back: color registers and one pixel pair per cycle, unless stalled, into the result register
   dlpd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .kangaroo_mode (kang_ff),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule
